// ===== hdl/nearest_gear_estimator_assert.svh =====
// Assertion macros for the nearest gear estimator checker.
// Depends on nothing; included by the checker file.
`ifndef NEAREST_GEAR_ESTIMATOR_ASSERT_SVH
`define NEAREST_GEAR_ESTIMATOR_ASSERT_SVH

// Same-cycle implication, disabled during reset
`define NGE_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) \
        (ante) |-> (cons)) else $error(msg);

// Consequent checked a fixed number of cycles after the antecedent
`define NGE_ASSERT_DLY(label, clk, rst_n, ante, dly, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) \
        (ante) |-> ##(dly) (cons)) else $error(msg);

`endif

// ===== hdl/nge_pkg.sv =====
// Package for the nearest gear estimator: payload structs, widths, register map.
// Used by nge_div, nearest_gear_estimator and nge_checker.
package nge_pkg;

    // Field widths
    localparam int RPM_W    = 15;
    localparam int SPEED_W  = 16;
    localparam int CIRC_W   = 13;
    localparam int FD_W     = 16;
    localparam int CNT_W    = 4;
    localparam int WORD_W   = 64;
    localparam int GEAR_W   = 4;
    localparam int RATIO_W  = 16;

    // Ratio arithmetic: num = rpm*circ*6*2^24, den = 1000*speed*fd
    localparam int PROD_W   = RPM_W + CIRC_W;          // rpm*circ
    localparam int SFD_W    = SPEED_W + FD_W;          // speed*fd
    localparam int SCALE_SH = 24;
    localparam int NUM_W    = PROD_W + 3 + SCALE_SH;   // *6 adds 3 bits
    localparam int DEN_W    = SFD_W + 10;              // *1000 adds 10 bits
    localparam int Q_W      = RATIO_W;

    // Accept edge to result-accept edge
    localparam int LATENCY  = 21;

    localparam logic [RATIO_W-1:0] NO_MATCH = '1;

    // Register map (index = paddr / 8)
    localparam int PADDR_W = 6;
    localparam int PDATA_W = 64;
    localparam int IDX_W   = 3;
    localparam logic [IDX_W-1:0] REG_CIRC     = 3'd0;
    localparam logic [IDX_W-1:0] REG_FD       = 3'd1;
    localparam logic [IDX_W-1:0] REG_COUNT    = 3'd2;
    localparam logic [IDX_W-1:0] REG_GEARS_LO = 3'd3;
    localparam logic [IDX_W-1:0] REG_GEARS_HI = 3'd4;

    // Reset values
    localparam logic [CIRC_W-1:0] CIRC_RST  = 13'd2000;
    localparam logic [FD_W-1:0]   FD_RST    = 16'd16384;
    localparam logic [CNT_W-1:0]  COUNT_RST = 4'd0;

    typedef struct packed {
        logic [RPM_W-1:0]   engine_rpm;
        logic [SPEED_W-1:0] vehicle_speed;
    } t_in_item;

    typedef struct packed {
        logic [GEAR_W-1:0]  gear;
        logic [RATIO_W-1:0] ratio_difference;
        logic [RATIO_W-1:0] computed_ratio;
    } t_out_item;

    // Control that travels alongside the divider data
    typedef struct packed {
        logic valid;
        logic zero_speed;
    } t_div_ctl;

endpackage

// ===== hdl/nge_div.sv =====
// Pipelined restoring divider with saturation at 2^16-1, one quotient bit per stage.
// Depends on nge_pkg.
module nge_div (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  nge_pkg::t_div_ctl          i_ctl,
    input  logic [nge_pkg::NUM_W-1:0]  i_num,
    input  logic [nge_pkg::DEN_W-1:0]  i_den,
    output nge_pkg::t_div_ctl          o_ctl,
    output logic [nge_pkg::Q_W-1:0]    o_quo
);

    localparam int NUM_W = nge_pkg::NUM_W;
    localparam int DEN_W = nge_pkg::DEN_W;
    localparam int Q_W   = nge_pkg::Q_W;
    localparam int CMP_W = DEN_W + Q_W;

    nge_pkg::t_div_ctl r_ctl [0:Q_W];
    logic [NUM_W-1:0]  r_rem [0:Q_W-1];
    logic [DEN_W-1:0]  r_den [0:Q_W-1];
    logic              r_sat [0:Q_W];
    logic [Q_W-1:0]    r_quo [1:Q_W];

    // Stage 0: overflow check, quotient saturates when den is zero or num >= den * 2^16
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl[0] <= '0;
        end else begin
            r_ctl[0] <= i_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem[0] <= i_num;
        r_den[0] <= i_den;
        r_sat[0] <= (i_den == '0) || (CMP_W'(i_num) >= {i_den, {Q_W{1'b0}}});
    end

    // Stages 1..Q_W: one compare-subtract each, MSB of the quotient first
    for (genvar g = 0; g < Q_W; g++) begin : g_step
        logic [CMP_W-1:0] w_sub;
        logic [CMP_W-1:0] w_diff;
        logic             w_ge;

        assign w_sub  = CMP_W'(r_den[g]) << (Q_W - 1 - g);
        assign w_ge   = CMP_W'(r_rem[g]) >= w_sub;
        assign w_diff = CMP_W'(r_rem[g]) - w_sub;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_ctl[g+1] <= '0;
            end else begin
                r_ctl[g+1] <= r_ctl[g];
            end
        end

        always_ff @(posedge i_clk) begin
            r_sat[g+1] <= r_sat[g];
        end

        if (g == 0) begin : g_first
            always_ff @(posedge i_clk) begin
                r_quo[1] <= {{(Q_W-1){1'b0}}, w_ge};
            end
        end else begin : g_rest
            always_ff @(posedge i_clk) begin
                r_quo[g+1] <= {r_quo[g][Q_W-2:0], w_ge};
            end
        end

        // final remainder is not needed
        if (g < Q_W - 1) begin : g_rem
            always_ff @(posedge i_clk) begin
                r_rem[g+1] <= w_ge ? w_diff[NUM_W-1:0] : r_rem[g];
                r_den[g+1] <= r_den[g];
            end
        end
    end

    assign o_ctl = r_ctl[Q_W];
    assign o_quo = r_sat[Q_W] ? {Q_W{1'b1}} : r_quo[Q_W];

endmodule

// ===== hdl/nearest_gear_estimator.sv =====
// Top level of the nearest gear estimator: config registers, ratio pipeline, gear search.
// Depends on nge_pkg and nge_div.
//
// Usage:
//   Items enter on start/i_item; one is taken at every clock edge where start is
//   high and busy is low. busy stays low, so an item can enter every cycle.
//   Each item gives exactly one result on o_result, marked by o_valid for one
//   cycle, in input order. The receiver cannot stall the block.
//   Throughput: one item per cycle. The depth is set by the divider, which
//   resolves one quotient bit per stage (16 stages plus an overflow check),
//   after two multiply stages and before a lane-difference stage and a
//   gear-select stage.
//   Configuration goes through the APB-style port; the data bus is 64 bits
//   wide, register i sits at byte address 8*i, pready is always high, and
//   reads return the register value. Write registers only while no item is
//   in flight.
//   Reset (i_rst_n low, synchronous) empties the pipeline and loads the
//   register defaults: 2000 mm tyre, final drive 4.0, no gears configured.
module nearest_gear_estimator #(
    parameter int MAX_GEARS = 8
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  nge_pkg::t_in_item             i_item,
    output logic                          o_valid,
    output nge_pkg::t_out_item            o_result,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [nge_pkg::PADDR_W-1:0]   paddr,
    input  logic [nge_pkg::PDATA_W-1:0]   pwdata,
    output logic [nge_pkg::PDATA_W-1:0]   prdata,
    output logic                          pready
);

    localparam int RATIO_W = nge_pkg::RATIO_W;
    localparam int GEAR_W  = nge_pkg::GEAR_W;
    localparam int CNT_W   = nge_pkg::CNT_W;

    // Config registers
    logic [nge_pkg::CIRC_W-1:0] r_circ;
    logic [nge_pkg::FD_W-1:0]   r_fd;
    logic [CNT_W-1:0]           r_count;
    logic [nge_pkg::WORD_W-1:0] r_gears_lo;
    logic [nge_pkg::WORD_W-1:0] r_gears_hi;

    logic [nge_pkg::IDX_W-1:0]  w_idx;
    logic                       w_wr;

    assign w_idx  = paddr[nge_pkg::PADDR_W-1:nge_pkg::PADDR_W-nge_pkg::IDX_W];
    assign w_wr   = psel && penable && pwrite;
    assign pready = 1'b1;
    assign busy   = 1'b0;

    // Register writes; unknown indexes are ignored
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_circ     <= nge_pkg::CIRC_RST;
            r_fd       <= nge_pkg::FD_RST;
            r_count    <= nge_pkg::COUNT_RST;
            r_gears_lo <= '0;
            r_gears_hi <= '0;
        end else if (w_wr) begin
            unique case (w_idx)
                nge_pkg::REG_CIRC:     r_circ     <= pwdata[nge_pkg::CIRC_W-1:0];
                nge_pkg::REG_FD:       r_fd       <= pwdata[nge_pkg::FD_W-1:0];
                nge_pkg::REG_COUNT:    r_count    <= pwdata[CNT_W-1:0];
                nge_pkg::REG_GEARS_LO: r_gears_lo <= pwdata;
                nge_pkg::REG_GEARS_HI: r_gears_hi <= pwdata;
                default: ;
            endcase
        end
    end

    // Register reads
    always_comb begin
        unique case (w_idx)
            nge_pkg::REG_CIRC:     prdata = nge_pkg::PDATA_W'(r_circ);
            nge_pkg::REG_FD:       prdata = nge_pkg::PDATA_W'(r_fd);
            nge_pkg::REG_COUNT:    prdata = nge_pkg::PDATA_W'(r_count);
            nge_pkg::REG_GEARS_LO: prdata = r_gears_lo;
            nge_pkg::REG_GEARS_HI: prdata = r_gears_hi;
            default:               prdata = '0;
        endcase
    end

    // Stage 1: rpm*circ and speed*fd
    logic                        r1_valid;
    logic                        r1_zs;
    logic [nge_pkg::PROD_W-1:0]  r1_prod;
    logic [nge_pkg::SFD_W-1:0]   r1_sfd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
        end else begin
            r1_valid <= start && !busy;
        end
    end

    always_ff @(posedge i_clk) begin
        r1_zs   <= (i_item.vehicle_speed == '0);
        r1_prod <= nge_pkg::PROD_W'(i_item.engine_rpm) * nge_pkg::PROD_W'(r_circ);
        r1_sfd  <= nge_pkg::SFD_W'(i_item.vehicle_speed) * nge_pkg::SFD_W'(r_fd);
    end

    // Stage 2: scale by 6*2^24 and by 1000
    logic                        r2_valid;
    logic                        r2_zs;
    logic [nge_pkg::NUM_W-1:0]   r2_num;
    logic [nge_pkg::DEN_W-1:0]   r2_den;
    logic [nge_pkg::PROD_W+2:0]  w_prod6;

    assign w_prod6 = ((nge_pkg::PROD_W+3)'(r1_prod) << 2) + ((nge_pkg::PROD_W+3)'(r1_prod) << 1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_valid <= 1'b0;
        end else begin
            r2_valid <= r1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r2_zs  <= r1_zs;
        r2_num <= {w_prod6, {nge_pkg::SCALE_SH{1'b0}}};
        r2_den <= nge_pkg::DEN_W'(r1_sfd) * nge_pkg::DEN_W'(1000);
    end

    // Divider stages
    nge_pkg::t_div_ctl     w_div_in;
    nge_pkg::t_div_ctl     w_div_out;
    logic [RATIO_W-1:0]    w_ratio;

    assign w_div_in.valid      = r2_valid;
    assign w_div_in.zero_speed = r2_zs;

    nge_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_div_in),
        .i_num   (r2_num),
        .i_den   (r2_den),
        .o_ctl   (w_div_out),
        .o_quo   (w_ratio)
    );

    // Stage 3: per-lane absolute differences, unused lanes read as no match
    logic                  r3_valid;
    logic                  r3_zs;
    logic [RATIO_W-1:0]    r3_ratio;
    logic [RATIO_W-1:0]    r3_diff [MAX_GEARS];
    logic [RATIO_W-1:0]    n3_diff [MAX_GEARS];
    logic [CNT_W-1:0]      w_count;
    logic [2*nge_pkg::WORD_W-1:0] w_gears;

    assign w_count = (r_count > CNT_W'(MAX_GEARS)) ? CNT_W'(MAX_GEARS) : r_count;
    assign w_gears = {r_gears_hi, r_gears_lo};

    always_comb begin
        for (int g = 0; g < MAX_GEARS; g++) begin
            if (CNT_W'(g) >= w_count) begin
                n3_diff[g] = nge_pkg::NO_MATCH;
            end else if (w_gears[g*RATIO_W +: RATIO_W] >= w_ratio) begin
                n3_diff[g] = w_gears[g*RATIO_W +: RATIO_W] - w_ratio;
            end else begin
                n3_diff[g] = w_ratio - w_gears[g*RATIO_W +: RATIO_W];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_valid <= 1'b0;
        end else begin
            r3_valid <= w_div_out.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r3_zs    <= w_div_out.zero_speed;
        r3_ratio <= w_ratio;
        r3_diff  <= n3_diff;
    end

    // Stage 4: pairwise minimum tree over the lanes, lower gear wins a tie; zero speed reports gear zero
    localparam int LANES = 2 * nge_pkg::WORD_W / RATIO_W;

    logic                  r_out_valid;
    nge_pkg::t_out_item    r_out;
    nge_pkg::t_out_item    n_out;

    always_comb begin
        logic [RATIO_W-1:0] lane_diff [LANES];
        logic [GEAR_W-1:0]  lane_gear [LANES];
        for (int g = 0; g < LANES; g++) begin
            lane_diff[g] = nge_pkg::NO_MATCH;
            lane_gear[g] = GEAR_W'(g + 1);
        end
        for (int g = 0; g < MAX_GEARS; g++) begin
            lane_diff[g] = r3_diff[g];
        end
        // left side holds the lower gears, so only a strictly smaller right side wins
        for (int s = 1; s < LANES; s = s * 2) begin
            for (int g = 0; g + s < LANES; g = g + 2 * s) begin
                if (lane_diff[g + s] < lane_diff[g]) begin
                    lane_diff[g] = lane_diff[g + s];
                    lane_gear[g] = lane_gear[g + s];
                end
            end
        end
        if (r3_zs) begin
            n_out.gear             = '0;
            n_out.ratio_difference = nge_pkg::NO_MATCH;
            n_out.computed_ratio   = '0;
        end else begin
            n_out.gear             = lane_gear[0];
            n_out.ratio_difference = lane_diff[0];
            n_out.computed_ratio   = r3_ratio;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= r3_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    assign o_valid  = r_out_valid;
    assign o_result = r_out;

endmodule

// ===== hdl/nge_checker.sv =====
// Port-level checker for the nearest gear estimator, bound to the top level.
// Depends on nge_pkg and nearest_gear_estimator_assert.svh.
`include "nearest_gear_estimator_assert.svh"

module nge_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               start,
    input logic               busy,
    input nge_pkg::t_in_item  i_item,
    input logic               o_valid,
    input nge_pkg::t_out_item o_result
);

    // every accepted item yields a result after the fixed latency
    `NGE_ASSERT_DLY(a_item_to_result, i_clk, i_rst_n, start && !busy, nge_pkg::LATENCY, o_valid, "accepted item gave no result")

    // no result without an item accepted the latency before
    `NGE_ASSERT_IMPL(a_no_invented, i_clk, i_rst_n, o_valid, $past(start && !busy && i_rst_n, nge_pkg::LATENCY), "result without accepted item")

    // zero speed always reports the no-motion result
    `NGE_ASSERT_DLY(a_zero_speed, i_clk, i_rst_n, start && !busy && (i_item.vehicle_speed == '0), nge_pkg::LATENCY, o_valid && (o_result.gear == '0) && (o_result.computed_ratio == '0) && (o_result.ratio_difference == nge_pkg::NO_MATCH), "zero speed result wrong")

    // gear zero only appears with the no-motion fields
    `NGE_ASSERT_IMPL(a_gear_zero, i_clk, i_rst_n, o_valid && (o_result.gear == '0), (o_result.computed_ratio == '0) && (o_result.ratio_difference == nge_pkg::NO_MATCH), "gear zero with motion fields")

endmodule

bind nearest_gear_estimator nge_checker u_nge_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .start    (start),
    .busy     (busy),
    .i_item   (i_item),
    .o_valid  (o_valid),
    .o_result (o_result)
);
